FILE: src/cfp_pkg.sv
// ----------------------------------------------------------------------------
// cfp_pkg: shared types and constants for the compliant follow controller
// Widths, register codes, controller/datapath command and status structs,
// and the full-turn sine table that is built at elaboration.
// ----------------------------------------------------------------------------
package cfp_pkg;

   localparam int NUM_MOTORS   = 3;
   localparam int MOTOR_SLOTS  = 3;
   localparam int FRAC_BITS    = 16;
   localparam int SINE_DEPTH   = 256;
   localparam int SINE_ADDR_W  = $clog2(SINE_DEPTH);
   localparam int SINE_W       = FRAC_BITS + 2;
   localparam int MOTOR_W      = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1;
   localparam int PIPE_DEPTH   = 5;

   localparam int POS_W        = 24;
   localparam int VOLT_W       = 21;
   localparam int RATE_W       = 17;
   localparam int GAIN_W       = 20;
   localparam int OFFS_W       = 20;
   localparam int CSR_IDX_W    = 3;
   localparam int CSR_DATA_W   = 20;

   localparam int POS_MAX      = (1 << (POS_W - 1)) - 1;
   localparam int POS_MIN      = -(1 << (POS_W - 1));
   localparam int HALF_LSB     = 1 << (FRAC_BITS - 1);
   localparam int IDX_LSB      = FRAC_BITS + 24 - SINE_ADDR_W;

   localparam logic [RATE_W-1:0] RATE_UNIT = RATE_W'(1 << FRAC_BITS);

   // 2^24 / (2 pi)
   localparam logic signed [22:0] INV_TWO_PI_Q24 = 23'sd2670177;

   localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   typedef enum logic {
      CMD_STEP  = 1'b0,
      CMD_RESET = 1'b1
   } command_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_FOLLOW_ALPHA   = 3'd0,
      REG_PROP_GAIN      = 3'd1,
      REG_VOLTAGE_LIMIT  = 3'd2,
      REG_GRAVITY_GAIN   = 3'd3,
      REG_GRAVITY_OFFSET = 3'd4,
      REG_INV_GEAR_RATIO = 3'd5
   } csr_index_type;

   localparam logic [RATE_W-1:0] FOLLOW_ALPHA_RESET   = 17'd1311;
   localparam logic [GAIN_W-1:0] PROP_GAIN_RESET      = 20'd6554;
   localparam logic [GAIN_W-1:0] VOLTAGE_LIMIT_RESET  = 20'd52429;
   localparam logic [GAIN_W-1:0] GRAVITY_GAIN_RESET   = 20'd98304;
   localparam logic [OFFS_W-1:0] GRAVITY_OFFSET_RESET = 20'hE1C29;
   localparam logic [RATE_W-1:0] INV_GEAR_RATIO_RESET = 17'd65536;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_DRAIN,
      ST_PUBLISH
   } ctrl_state_type;

   typedef struct packed {
      logic [RATE_W-1:0] follow_alpha;
      logic [GAIN_W-1:0] prop_gain;
      logic [GAIN_W-1:0] voltage_limit;
      logic [GAIN_W-1:0] gravity_gain;
      logic [OFFS_W-1:0] gravity_offset;
      logic [RATE_W-1:0] inv_gear_ratio;
   } cfg_type;

   typedef struct packed {
      logic               capture;
      logic               issue;
      logic [MOTOR_W-1:0] motor;
      logic               publish;
   } dp_cmd_type;

   typedef struct packed {
      logic pipe_busy;
   } dp_status_type;

   typedef logic signed [SINE_W-1:0] sine_table_type [SINE_DEPTH];

   // Taylor series to x^11 in Q30, folded over the four quadrants
   function automatic sine_table_type build_sine_table();
      sine_table_type tab;
      logic [63:0]    u;
      logic [63:0]    r;
      logic [63:0]    x;
      logic [63:0]    x2;
      logic [63:0]    t;
      logic [63:0]    s;
      logic [63:0]    e;
      logic [1:0]     quad;
      for (int k = 0; k < SINE_DEPTH; k++) begin
         u    = (64'(k) << 32) / SINE_DEPTH;
         quad = u[31:30];
         r    = {34'd0, u[29:0]};
         if (quad[0]) begin
            r = Q30_ONE - r;
         end
         x  = (r * HALF_PI_Q30) >> 30;
         x2 = (x * x) >> 30;
         t  = Q30_ONE - x2 / 64'd110;
         t  = Q30_ONE - ((x2 * t) >> 30) / 64'd72;
         t  = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
         t  = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
         t  = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
         s  = (x * t) >> 30;
         e  = (s + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
         tab[k] = quad[1] ? -SINE_W'(e) : SINE_W'(e);
      end
      return tab;
   endfunction

   localparam sine_table_type SINE_TABLE = build_sine_table();

endpackage

FILE: src/cfp_if.sv
// ----------------------------------------------------------------------------
// cfp channel interfaces
// Valid/ready channels for control items, drive results and register writes.
// ----------------------------------------------------------------------------
interface cfp_req_if;
   import cfp_pkg::*;

   logic                    valid;
   logic                    ready;
   logic                    command;
   logic signed [POS_W-1:0] position_a;
   logic signed [POS_W-1:0] position_b;
   logic signed [POS_W-1:0] position_c;

   modport source (output valid, output command, output position_a,
                   output position_b, output position_c, input ready);
   modport sink   (input valid, input command, input position_a,
                   input position_b, input position_c, output ready);
endinterface

interface cfp_rsp_if;
   import cfp_pkg::*;

   logic                     valid;
   logic                     ready;
   logic signed [VOLT_W-1:0] voltage_a;
   logic signed [VOLT_W-1:0] voltage_b;
   logic signed [VOLT_W-1:0] voltage_c;

   modport source (output valid, output voltage_a, output voltage_b,
                   output voltage_c, input ready);
   modport sink   (input valid, input voltage_a, input voltage_b,
                   input voltage_c, output ready);
endinterface

interface cfp_csr_if;
   import cfp_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: src/cfp_csr.sv
// ----------------------------------------------------------------------------
// cfp_csr: configuration register file
// Holds the six tuning registers; rate registers are clipped to one on read.
// ----------------------------------------------------------------------------
module cfp_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           wr_en,
   input  logic [cfp_pkg::CSR_IDX_W-1:0]  wr_index,
   input  logic [cfp_pkg::CSR_DATA_W-1:0] wr_data,
   output cfp_pkg::cfg_type               cfg
);
   import cfp_pkg::*;

   cfg_type regs_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff.follow_alpha   <= FOLLOW_ALPHA_RESET;
         regs_ff.prop_gain      <= PROP_GAIN_RESET;
         regs_ff.voltage_limit  <= VOLTAGE_LIMIT_RESET;
         regs_ff.gravity_gain   <= GRAVITY_GAIN_RESET;
         regs_ff.gravity_offset <= GRAVITY_OFFSET_RESET;
         regs_ff.inv_gear_ratio <= INV_GEAR_RATIO_RESET;
      end else if (wr_en) begin
         case (wr_index)
            REG_FOLLOW_ALPHA:   regs_ff.follow_alpha   <= wr_data[RATE_W-1:0];
            REG_PROP_GAIN:      regs_ff.prop_gain      <= wr_data[GAIN_W-1:0];
            REG_VOLTAGE_LIMIT:  regs_ff.voltage_limit  <= wr_data[GAIN_W-1:0];
            REG_GRAVITY_GAIN:   regs_ff.gravity_gain   <= wr_data[GAIN_W-1:0];
            REG_GRAVITY_OFFSET: regs_ff.gravity_offset <= wr_data[OFFS_W-1:0];
            REG_INV_GEAR_RATIO: regs_ff.inv_gear_ratio <= wr_data[RATE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      cfg = regs_ff;
      if (regs_ff.follow_alpha > RATE_UNIT) begin
         cfg.follow_alpha = RATE_UNIT;
      end
      if (regs_ff.inv_gear_ratio > RATE_UNIT) begin
         cfg.inv_gear_ratio = RATE_UNIT;
      end
   end

endmodule

FILE: src/cfp_ctrl.sv
// ----------------------------------------------------------------------------
// cfp_ctrl: transaction sequencer
// Accepts a control transaction, feeds the motors one per cycle into the
// datapath pipeline, waits for it to drain and hands the result to the
// output register; a reset transaction goes straight to the hand-off.
// ----------------------------------------------------------------------------
module cfp_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_command,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output cfp_pkg::dp_cmd_type    cmd,
   input  cfp_pkg::dp_status_type status
);
   import cfp_pkg::*;

   localparam logic [MOTOR_W-1:0] LAST_MOTOR = MOTOR_W'(NUM_MOTORS - 1);

   ctrl_state_type     state_ff;
   ctrl_state_type     state_in;
   logic [MOTOR_W-1:0] motor_ff;
   logic [MOTOR_W-1:0] motor_in;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic               out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         motor_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         motor_ff     <= motor_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      motor_in  = motor_ff;
      cmd       = '0;
      req_ready = 1'b0;
      out_free  = !rsp_valid_ff || rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               motor_in    = '0;
               // a reset transaction carries no work: publish zeros
               state_in    = (req_command == CMD_RESET) ? ST_PUBLISH : ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            cmd.issue = 1'b1;
            cmd.motor = motor_ff;
            if (motor_ff == LAST_MOTOR) begin
               state_in = ST_DRAIN;
            end else begin
               motor_in = motor_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            if (!status.pipe_busy) begin
               state_in = ST_PUBLISH;
            end
         end
         ST_PUBLISH: begin
            if (out_free) begin
               cmd.publish = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rsp_valid_in = cmd.publish || (rsp_valid_ff && !rsp_ready);
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: src/cfp_dp.sv
// ----------------------------------------------------------------------------
// cfp_dp: control law datapath
// Five register stages shared by the motors: follow and arm-angle products,
// reference update, phase and error products, sine lookup, gravity product,
// then sum and clamp into the result bank.
// ----------------------------------------------------------------------------
module cfp_dp (
   input  logic                                 clock,
   input  logic                                 reset,
   input  cfp_pkg::dp_cmd_type                  cmd,
   output cfp_pkg::dp_status_type               status,
   input  cfp_pkg::cfg_type                     cfg,
   input  logic                                 req_command,
   input  logic signed [cfp_pkg::POS_W-1:0]     req_position_a,
   input  logic signed [cfp_pkg::POS_W-1:0]     req_position_b,
   input  logic signed [cfp_pkg::POS_W-1:0]     req_position_c,
   output logic signed [cfp_pkg::VOLT_W-1:0]    rsp_voltage_a,
   output logic signed [cfp_pkg::VOLT_W-1:0]    rsp_voltage_b,
   output logic signed [cfp_pkg::VOLT_W-1:0]    rsp_voltage_c
);
   import cfp_pkg::*;

   localparam int DIFF_W  = POS_W + 1;
   localparam int FOL_W   = RATE_W + 1 + DIFF_W;
   localparam int ARM_W   = POS_W + RATE_W + 1;
   localparam int STEP_W  = FOL_W - FRAC_BITS;
   localparam int SUM_W   = STEP_W + 1;
   localparam int ANG_W   = ARM_W - FRAC_BITS + 1;
   localparam int PHASE_W = ANG_W + 23;
   localparam int PROP_W  = GAIN_W + 1 + DIFF_W;
   localparam int UP_W    = PROP_W - FRAC_BITS;
   localparam int GRAV_W  = GAIN_W + 1 + SINE_W;
   localparam int GV_W    = GRAV_W - FRAC_BITS;
   localparam int TOT_W   = UP_W + 1;

   // transaction state
   logic                     init_ff;
   logic                     first_ff;
   logic signed [POS_W-1:0]  pos_ff [MOTOR_SLOTS];
   logic signed [POS_W-1:0]  ref_ff [NUM_MOTORS];
   logic signed [VOLT_W-1:0] volt_ff [MOTOR_SLOTS];
   logic signed [VOLT_W-1:0] out_ff [MOTOR_SLOTS];

   // pipeline tags
   logic [PIPE_DEPTH-1:0]    vld_ff;
   logic [MOTOR_W-1:0]       mot_ff [PIPE_DEPTH];

   // stage registers
   logic signed [POS_W-1:0]   s1_pos_ff;
   logic signed [POS_W-1:0]   s1_ref_ff;
   logic signed [FOL_W-1:0]   s1_follow_ff;
   logic signed [ARM_W-1:0]   s1_arm_ff;
   logic signed [POS_W-1:0]   s2_pos_ff;
   logic signed [POS_W-1:0]   s2_ref_ff;
   logic signed [ANG_W-1:0]   s2_angle_ff;
   logic signed [PHASE_W-1:0] s3_phase_ff;
   logic signed [PROP_W-1:0]  s3_prop_ff;
   logic signed [SINE_W-1:0]  s4_sine_ff;
   logic signed [UP_W-1:0]    s4_up_ff;
   logic signed [GRAV_W-1:0]  s5_grav_ff;
   logic signed [UP_W-1:0]    s5_up_ff;

   // stage 1
   logic signed [POS_W-1:0]   s1_pos_in;
   logic signed [POS_W-1:0]   s1_ref_in;
   logic signed [DIFF_W-1:0]  follow_diff;
   logic signed [RATE_W:0]    alpha_s;
   logic signed [RATE_W:0]    inv_s;
   logic signed [FOL_W-1:0]   follow_prod;
   logic signed [ARM_W-1:0]   arm_prod;

   // stage 2
   logic signed [FOL_W-1:0]   follow_rnd;
   logic signed [STEP_W-1:0]  follow_step;
   logic signed [SUM_W-1:0]   ref_sum;
   logic signed [POS_W-1:0]   ref_new;
   logic signed [ARM_W-1:0]   arm_rnd;
   logic signed [ANG_W-2:0]   arm_angle;
   logic signed [ANG_W-1:0]   angle;

   // stage 3
   logic signed [DIFF_W-1:0]  track_err;
   logic signed [GAIN_W:0]    prop_s;
   logic signed [PHASE_W-1:0] phase_prod;
   logic signed [PROP_W-1:0]  prop_prod;

   // stage 4
   logic signed [PHASE_W-1:0] phase_rnd;
   logic [SINE_ADDR_W-1:0]    sine_idx;
   logic signed [PROP_W-1:0]  prop_rnd;

   // stage 5
   logic signed [GAIN_W:0]    grav_gain_s;
   logic signed [GRAV_W-1:0]  grav_prod;

   // sum and clamp
   logic signed [GRAV_W-1:0]  grav_rnd;
   logic signed [GV_W-1:0]    grav_term;
   logic signed [TOT_W-1:0]   total;
   logic signed [TOT_W-1:0]   lim_s;
   logic signed [TOT_W-1:0]   clamped;

   always_comb begin
      s1_pos_in   = pos_ff[cmd.motor];
      s1_ref_in   = first_ff ? s1_pos_in : ref_ff[cmd.motor];
      follow_diff = DIFF_W'(s1_pos_in) - DIFF_W'(s1_ref_in);
      alpha_s     = {1'b0, cfg.follow_alpha};
      inv_s       = {1'b0, cfg.inv_gear_ratio};
      follow_prod = alpha_s * follow_diff;
      arm_prod    = s1_pos_in * inv_s;
   end

   always_comb begin
      follow_rnd  = s1_follow_ff + FOL_W'(HALF_LSB);
      follow_step = follow_rnd[FOL_W-1:FRAC_BITS];
      ref_sum     = SUM_W'(s1_ref_ff) + SUM_W'(follow_step);
      if (ref_sum > SUM_W'(POS_MAX)) begin
         ref_new = POS_W'(POS_MAX);
      end else if (ref_sum < SUM_W'(POS_MIN)) begin
         ref_new = POS_W'(POS_MIN);
      end else begin
         ref_new = ref_sum[POS_W-1:0];
      end
      arm_rnd   = s1_arm_ff + ARM_W'(HALF_LSB);
      arm_angle = arm_rnd[ARM_W-1:FRAC_BITS];
      angle     = ANG_W'(arm_angle) + ANG_W'($signed(cfg.gravity_offset));
   end

   always_comb begin
      track_err  = DIFF_W'(s2_ref_ff) - DIFF_W'(s2_pos_ff);
      prop_s     = {1'b0, cfg.prop_gain};
      phase_prod = s2_angle_ff * INV_TWO_PI_Q24;
      prop_prod  = prop_s * track_err;
   end

   always_comb begin
      // round the turn fraction to the nearest table entry, wrap by truncation
      phase_rnd = s3_phase_ff + (PHASE_W'(1) <<< (IDX_LSB - 1));
      sine_idx  = phase_rnd[IDX_LSB +: SINE_ADDR_W];
      prop_rnd  = s3_prop_ff + PROP_W'(HALF_LSB);
   end

   always_comb begin
      grav_gain_s = {1'b0, cfg.gravity_gain};
      grav_prod   = grav_gain_s * s4_sine_ff;
   end

   always_comb begin
      grav_rnd  = s5_grav_ff + GRAV_W'(HALF_LSB);
      grav_term = grav_rnd[GRAV_W-1:FRAC_BITS];
      total     = TOT_W'(s5_up_ff) + TOT_W'(grav_term);
      lim_s     = TOT_W'({1'b0, cfg.voltage_limit});
      if (total > lim_s) begin
         clamped = lim_s;
      end else if (total < -lim_s) begin
         clamped = -lim_s;
      end else begin
         clamped = total;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         init_ff  <= 1'b0;
         first_ff <= 1'b0;
         vld_ff   <= '0;
         for (int i = 0; i < NUM_MOTORS; i++) begin
            ref_ff[i] <= '0;
         end
         for (int i = 0; i < MOTOR_SLOTS; i++) begin
            volt_ff[i] <= '0;
         end
      end else begin
         vld_ff <= {vld_ff[PIPE_DEPTH-2:0], cmd.issue};
         if (cmd.capture) begin
            for (int i = 0; i < MOTOR_SLOTS; i++) begin
               volt_ff[i] <= '0;
            end
            if (req_command == CMD_RESET) begin
               init_ff <= 1'b0;
            end else begin
               first_ff <= !init_ff;
               init_ff  <= 1'b1;
            end
         end
         if (vld_ff[0]) begin
            ref_ff[mot_ff[0]] <= ref_new;
         end
         if (vld_ff[PIPE_DEPTH-1]) begin
            volt_ff[mot_ff[PIPE_DEPTH-1]] <= clamped[VOLT_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         pos_ff[0] <= req_position_a;
         pos_ff[1] <= req_position_b;
         pos_ff[2] <= req_position_c;
      end
      mot_ff[0] <= cmd.motor;
      for (int i = 1; i < PIPE_DEPTH; i++) begin
         mot_ff[i] <= mot_ff[i-1];
      end
      s1_pos_ff    <= s1_pos_in;
      s1_ref_ff    <= s1_ref_in;
      s1_follow_ff <= follow_prod;
      s1_arm_ff    <= arm_prod;
      s2_pos_ff    <= s1_pos_ff;
      s2_ref_ff    <= ref_new;
      s2_angle_ff  <= angle;
      s3_phase_ff  <= phase_prod;
      s3_prop_ff   <= prop_prod;
      s4_sine_ff   <= SINE_TABLE[sine_idx];
      s4_up_ff     <= prop_rnd[PROP_W-1:FRAC_BITS];
      s5_grav_ff   <= grav_prod;
      s5_up_ff     <= s4_up_ff;
      if (cmd.publish) begin
         for (int i = 0; i < MOTOR_SLOTS; i++) begin
            out_ff[i] <= volt_ff[i];
         end
      end
   end

   assign status.pipe_busy = |vld_ff;
   assign rsp_voltage_a    = out_ff[0];
   assign rsp_voltage_b    = out_ff[1];
   assign rsp_voltage_c    = out_ff[2];

endmodule

FILE: src/compliant_follow_p_control.sv
// ----------------------------------------------------------------------------
// compliant_follow_p_control: soft proportional follow with gravity feedforward
//
//   Channel  Dir  Carries
//   req_ch   in   command, position_a, position_b, position_c
//   rsp_ch   out  voltage_a, voltage_b, voltage_c
//   csr_ch   in   index, data (six tuning registers, always ready)
//
// In a control transaction the three motors enter the five-stage multiplier
// pipeline one per cycle and the result bank is copied to the output register
// once the pipeline drains; the next transaction is accepted after that.
// A reset transaction skips the pipeline and returns zero voltages.
// Reset is synchronous: registers return to their defaults, the references
// clear and the controller is uninitialised.
// While rsp_ch is stalled the result holds in its output register; the next
// transaction is still taken and computed, and waits to publish.
// ----------------------------------------------------------------------------
module compliant_follow_p_control (
   input logic       clock,
   input logic       reset,
   cfp_req_if.sink   req_ch,
   cfp_rsp_if.source rsp_ch,
   cfp_csr_if.sink   csr_ch
);
   import cfp_pkg::*;

   cfg_type       cfg;
   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   assign csr_ch.ready = 1'b1;

   cfp_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_ch.valid),
      .wr_index (csr_ch.index),
      .wr_data  (csr_ch.data),
      .cfg      (cfg)
   );

   cfp_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_ch.valid),
      .req_command (req_ch.command),
      .req_ready   (req_ch.ready),
      .rsp_valid   (rsp_ch.valid),
      .rsp_ready   (rsp_ch.ready),
      .cmd         (dp_cmd),
      .status      (dp_status)
   );

   cfp_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (dp_cmd),
      .status         (dp_status),
      .cfg            (cfg),
      .req_command    (req_ch.command),
      .req_position_a (req_ch.position_a),
      .req_position_b (req_ch.position_b),
      .req_position_c (req_ch.position_c),
      .rsp_voltage_a  (rsp_ch.voltage_a),
      .rsp_voltage_b  (rsp_ch.voltage_b),
      .rsp_voltage_c  (rsp_ch.voltage_c)
   );

   // a new transaction must never overlap motors still in flight
   a_accept_when_drained: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |-> !dp_status.pipe_busy)
      else $error("transaction accepted while pipeline busy");

   a_issue_enters_pipe: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.issue |=> dp_status.pipe_busy)
      else $error("issued motor did not enter pipeline");

   a_result_from_publish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_ch.valid) |-> $past(dp_cmd.publish))
      else $error("result valid without publish");

endmodule

FILE: sim/compliant_follow_p_control_test.sv
// ----------------------------------------------------------------------------
// compliant_follow_p_control_test: self-checking bench for the follow controller
// Walks a short table of directed transactions, then long random runs under many
// register settings. Each drive result is checked against the row's value if it
// gives one, else an in-bench fixed-point model of follow, sine lookup and clamp.
// ----------------------------------------------------------------------------
module compliant_follow_p_control_test;
   import cfp_pkg::*;

   localparam longint POS_HI      = 8388607;
   localparam longint POS_LO      = -8388608;
   localparam int     VOLT_HI     = 1048575;
   localparam longint UNIT        = 65536;
   localparam longint TURN_STEPS  = 256;
   localparam longint INV_TWO_PI  = 2670177;
   localparam int     CYCLE_LIMIT = 500000;
   localparam int     PHASE_ITEMS = 150;
   localparam int     PHASES      = 11;
   localparam int     HOLD_PHASE  = 3;

   // register settings used by the directed table
   localparam int CFG_KEEP       = 0;
   localparam int CFG_SATURATE   = 1;
   localparam int CFG_ZERO_LIMIT = 2;
   localparam int CFG_OVERSIZE   = 3;
   localparam int CFG_HALF       = 4;

   typedef logic [2:0][VOLT_W-1:0] drive_set_type;

   typedef struct packed {
      logic          known;
      drive_set_type volts;
   } known_drive_type;

   typedef struct {
      int          cfg;
      command_type cmd;
      longint      pa;
      longint      pb;
      longint      pc;
      logic        known;
      int          va;
      int          vb;
      int          vc;
   } directed_row_type;

   logic clock;
   logic reset;

   cfp_req_if req_ch ();
   cfp_rsp_if rsp_ch ();
   cfp_csr_if csr_ch ();

   compliant_follow_p_control DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // model copy of the tuning registers and follow state
   logic [RATE_W-1:0]        k_alpha;
   logic [GAIN_W-1:0]        k_prop;
   logic [GAIN_W-1:0]        v_limit;
   logic [GAIN_W-1:0]        g_gain;
   logic signed [OFFS_W-1:0] g_offset;
   logic [RATE_W-1:0]        gear_inv;
   longint                   follow_ref [3];
   logic                     follow_armed;

   drive_set_type   awaited_drive [$];
   known_drive_type known_drive [$];
   int              sent_count;
   int              received_count;
   int              error_count;
   int              cycle_count;
   int              gap_pct;
   int              stall_pct;
   int              rsp_hold_cycles;
   string           field_name [3] = '{"voltage_a", "voltage_b", "voltage_c"};

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   function automatic longint round_q(longint v, int s);
      return (v + (longint'(1) << (s - 1))) >>> s;
   endfunction

   // quarter-wave Taylor sine in Q30, folded to a full turn of TURN_STEPS
   function automatic longint sine_lookup(longint angle);
      longint      idx;
      logic [63:0] ph;
      logic [63:0] r;
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] t;
      logic [63:0] s;
      logic [63:0] mag;
      logic [63:0] one;
      int unsigned divisors [4] = '{72, 42, 20, 6};
      idx = round_q(angle * TURN_STEPS * INV_TWO_PI, FRAC_BITS + 24);
      one = 64'd1 << 30;
      ph  = (64'(idx[7:0]) << 32) / 64'(TURN_STEPS);
      r   = {34'd0, ph[29:0]};
      if (ph[30]) begin
         r = one - r;
      end
      x  = (r * 64'd1686629713) >> 30;
      x2 = (x * x) >> 30;
      t  = one - x2 / 64'd110;
      foreach (divisors[n]) begin
         t = one - ((x2 * t) >> 30) / 64'(divisors[n]);
      end
      s   = (x * t) >> 30;
      mag = (s + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
      return ph[31] ? -longint'(mag) : longint'(mag);
   endfunction

   // advance the follow references and work out the three drive voltages
   function automatic drive_set_type predict_drive(command_type cmd,
                                                   logic signed [POS_W-1:0] pa,
                                                   logic signed [POS_W-1:0] pb,
                                                   logic signed [POS_W-1:0] pc);
      drive_set_type volts;
      longint        pos [3];
      longint        alpha;
      longint        inv;
      longint        lim;
      longint        r;
      longint        grav;
      longint        up;
      longint        tot;
      volts = '0;
      if (cmd == CMD_RESET) begin
         follow_armed = 1'b0;
         return volts;
      end
      pos[0] = pa;
      pos[1] = pb;
      pos[2] = pc;
      alpha  = (longint'(k_alpha) > UNIT) ? UNIT : longint'(k_alpha);
      inv    = (longint'(gear_inv) > UNIT) ? UNIT : longint'(gear_inv);
      lim    = longint'(v_limit);
      if (!follow_armed) begin
         foreach (pos[m]) follow_ref[m] = pos[m];
         follow_armed = 1'b1;
      end
      for (int m = 0; m < NUM_MOTORS; m++) begin
         r = follow_ref[m] + round_q(alpha * (pos[m] - follow_ref[m]), 16);
         if (r > POS_HI) r = POS_HI;
         if (r < POS_LO) r = POS_LO;
         follow_ref[m] = r;
         grav = round_q(longint'(g_gain) *
                        sine_lookup(round_q(pos[m] * inv, 16) + longint'(g_offset)),
                        FRAC_BITS);
         up   = round_q(longint'(k_prop) * (r - pos[m]), FRAC_BITS);
         tot  = up + grav;
         if (tot > lim) tot = lim;
         if (tot < -lim) tot = -lim;
         volts[m] = tot[VOLT_W-1:0];
      end
      return volts;
   endfunction

   task automatic report_mismatch(input string note);
      error_count++;
      $display("%0t: %s", $time, note);
   endtask

   // scoreboard: results first, then register writes, then new transactions
   always @(posedge clock) begin
      drive_set_type   got;
      drive_set_type   want;
      known_drive_type hint;
      if (reset) begin
         k_alpha      = 17'd1311;
         k_prop       = 20'd6554;
         v_limit      = 20'd52429;
         g_gain       = 20'd98304;
         g_offset     = -20'sd123863;
         gear_inv     = 17'd65536;
         follow_armed = 1'b0;
         foreach (follow_ref[m]) follow_ref[m] = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            received_count++;
            got = {rsp_ch.voltage_c, rsp_ch.voltage_b, rsp_ch.voltage_a};
            if (awaited_drive.size() == 0) begin
               report_mismatch($sformatf("unexpected drive result %0d %0d %0d",
                  $signed(got[0]), $signed(got[1]), $signed(got[2])));
            end else begin
               want = awaited_drive.pop_front();
               for (int m = 0; m < 3; m++) begin
                  if (got[m] !== want[m]) begin
                     report_mismatch($sformatf("result %0d %s: got %0d, expected %0d",
                        received_count, field_name[m], $signed(got[m]),
                        $signed(want[m])));
                  end
               end
            end
         end
         if (csr_ch.valid && csr_ch.ready) begin
            case (csr_index_type'(csr_ch.index))
               REG_FOLLOW_ALPHA:   k_alpha  = csr_ch.data[RATE_W-1:0];
               REG_PROP_GAIN:      k_prop   = csr_ch.data[GAIN_W-1:0];
               REG_VOLTAGE_LIMIT:  v_limit  = csr_ch.data[GAIN_W-1:0];
               REG_GRAVITY_GAIN:   g_gain   = csr_ch.data[GAIN_W-1:0];
               REG_GRAVITY_OFFSET: g_offset = csr_ch.data[OFFS_W-1:0];
               REG_INV_GEAR_RATIO: gear_inv = csr_ch.data[RATE_W-1:0];
               default: ;
            endcase
         end
         if (req_ch.valid && req_ch.ready) begin
            want = predict_drive(command_type'(req_ch.command), req_ch.position_a,
                                 req_ch.position_b, req_ch.position_c);
            hint = known_drive.pop_front();
            awaited_drive.push_back(hint.known ? hint.volts : want);
         end
      end
   end

   // result side: random stall bursts plus an occasional long hold-off
   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         if (rsp_hold_cycles > 0) begin
            rsp_ch.ready <= 1'b0;
            @(posedge clock);
            rsp_hold_cycles--;
         end else if ($urandom_range(0, 99) < stall_pct) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clock);
         end else begin
            rsp_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 16)) @(posedge clock);
         end
      end
   end

   task automatic send_item(input command_type cmd, input longint pa, input longint pb,
                            input longint pc, input logic known,
                            input drive_set_type volts);
      known_drive.push_back('{known, volts});
      req_ch.valid      <= 1'b1;
      req_ch.command    <= cmd;
      req_ch.position_a <= POS_W'(pa);
      req_ch.position_b <= POS_W'(pb);
      req_ch.position_c <= POS_W'(pc);
      do @(posedge clock); while (!req_ch.ready);
      sent_count++;
   endtask

   task automatic pause_sender();
      if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      while (received_count != sent_count) @(posedge clock);
   endtask

   task automatic program_registers(input logic [CSR_DATA_W-1:0] alpha,
                                    input logic [CSR_DATA_W-1:0] prop,
                                    input logic [CSR_DATA_W-1:0] limit,
                                    input logic [CSR_DATA_W-1:0] gain,
                                    input logic [CSR_DATA_W-1:0] offs,
                                    input logic [CSR_DATA_W-1:0] inv);
      csr_index_type         idx [6];
      logic [CSR_DATA_W-1:0] word [6];
      idx  = '{REG_FOLLOW_ALPHA, REG_PROP_GAIN, REG_VOLTAGE_LIMIT,
               REG_GRAVITY_GAIN, REG_GRAVITY_OFFSET, REG_INV_GEAR_RATIO};
      word = '{alpha, prop, limit, gain, offs, inv};
      foreach (idx[k]) begin
         csr_ch.valid <= 1'b1;
         csr_ch.index <= idx[k];
         csr_ch.data  <= word[k];
         do @(posedge clock); while (!csr_ch.ready);
      end
      csr_ch.valid <= 1'b0;
   endtask

   function automatic logic [CSR_DATA_W-1:0] pick_rate();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return CSR_DATA_W'(UNIT);
         2:       return CSR_DATA_W'($urandom_range(65537, 20'hFFFFF));
         5:       return CSR_DATA_W'($urandom_range(0, 4096));
         default: return CSR_DATA_W'($urandom_range(0, 65536));
      endcase
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_gain();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return 20'hFFFFF;
         2, 3:    return CSR_DATA_W'($urandom_range(0, 20'hFFFFF));
         default: return CSR_DATA_W'($urandom_range(0, 262144));
      endcase
   endfunction

   initial begin
      directed_row_type rows [23];
      drive_set_type    volts;
      drive_set_type    no_volts;
      longint           walk_pos [3];
      longint           p [3];
      longint           delta;
      command_type      cmd;
      int               roll;

      reset             <= 1'b1;
      req_ch.valid      <= 1'b0;
      req_ch.command    <= CMD_STEP;
      req_ch.position_a <= '0;
      req_ch.position_b <= '0;
      req_ch.position_c <= '0;
      csr_ch.valid      <= 1'b0;
      csr_ch.index      <= REG_FOLLOW_ALPHA;
      csr_ch.data       <= '0;
      sent_count        = 0;
      gap_pct           = 20;
      stall_pct         = 20;
      rsp_hold_cycles   = 0;
      no_volts          = '0;
      foreach (walk_pos[m]) walk_pos[m] = 0;

      rows = '{
         '{CFG_KEEP,       CMD_RESET, 0, 0, 0,                 1, 0, 0, 0},
         '{CFG_KEEP,       CMD_STEP,  0, 0, 0,                 0, 0, 0, 0},
         '{CFG_KEEP,       CMD_STEP,  POS_HI, POS_LO, 1,       0, 0, 0, 0},
         '{CFG_KEEP,       CMD_STEP,  POS_LO, POS_HI, -1,      0, 0, 0, 0},
         '{CFG_KEEP,       CMD_STEP,  411775, -411775, 102944, 0, 0, 0, 0},
         '{CFG_KEEP,       CMD_RESET, -1, POS_HI, POS_LO,      1, 0, 0, 0},
         '{CFG_KEEP,       CMD_STEP,  65536, -65536, 205887,   0, 0, 0, 0},
         '{CFG_KEEP,       CMD_STEP,  70000, -60000, 200000,   0, 0, 0, 0},
         '{CFG_SATURATE,   CMD_RESET, 0, 0, 0,                 1, 0, 0, 0},
         '{CFG_KEEP,       CMD_STEP,  0, 0, 0,                 1, 0, 0, 0},
         '{CFG_KEEP,       CMD_STEP,  POS_HI, POS_LO, 0,       1, -VOLT_HI, VOLT_HI, 0},
         '{CFG_KEEP,       CMD_STEP,  POS_LO, POS_HI, 0,       1, VOLT_HI, -VOLT_HI, 0},
         '{CFG_KEEP,       CMD_STEP,  5592405, -2796203, 3,    0, 0, 0, 0},
         '{CFG_ZERO_LIMIT, CMD_STEP,  POS_HI, POS_LO, POS_HI,  1, 0, 0, 0},
         '{CFG_KEEP,       CMD_STEP,  2796202, -1, 0,          1, 0, 0, 0},
         '{CFG_OVERSIZE,   CMD_RESET, 0, 0, 0,                 1, 0, 0, 0},
         '{CFG_KEEP,       CMD_STEP,  1000, -1000, 0,          0, 0, 0, 0},
         '{CFG_KEEP,       CMD_STEP,  300000, -300000, POS_HI, 0, 0, 0, 0},
         '{CFG_KEEP,       CMD_STEP,  POS_LO, 0, 12345,        0, 0, 0, 0},
         '{CFG_HALF,       CMD_STEP,  102944, -102944, 0,      0, 0, 0, 0},
         '{CFG_KEEP,       CMD_STEP,  -205887, 308831, -1,     0, 0, 0, 0},
         '{CFG_KEEP,       CMD_RESET, 0, 0, 0,                 1, 0, 0, 0},
         '{CFG_KEEP,       CMD_STEP,  4096, -4096, 65535,      0, 0, 0, 0}
      };

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (rows[i]) begin
         if (rows[i].cfg != CFG_KEEP) begin
            req_ch.valid <= 1'b0;
            wait_drained();
            case (rows[i].cfg)
               CFG_SATURATE:   program_registers('0, 20'hFFFFF, 20'hFFFFF, '0,
                                                 20'd411775, '0);
               CFG_ZERO_LIMIT: program_registers(20'h1FFFF, 20'h80000, '0, 20'hFFFFF,
                                                 CSR_DATA_W'(-411775), 20'h1FFFF);
               CFG_OVERSIZE:   program_registers(20'd65537, 20'd6554, 20'hFFFFF,
                                                 20'hFFFFF, 20'd411775, 20'd65537);
               default:        program_registers(20'd32768, 20'd65536, 20'd300000,
                                                 20'd98304, '0, 20'd32768);
            endcase
         end
         pause_sender();
         volts[0] = VOLT_W'(rows[i].va);
         volts[1] = VOLT_W'(rows[i].vb);
         volts[2] = VOLT_W'(rows[i].vc);
         send_item(rows[i].cmd, rows[i].pa, rows[i].pb, rows[i].pc, rows[i].known, volts);
      end

      for (int ph = 0; ph < PHASES; ph++) begin
         req_ch.valid <= 1'b0;
         wait_drained();
         if (ph == 0) begin
            program_registers(20'd1311, 20'd6554, 20'd52429, 20'd98304,
                              CSR_DATA_W'(-123863), 20'd65536);
         end else begin
            program_registers(pick_rate(), pick_gain(), pick_gain(), pick_gain(),
                              ($urandom_range(0, 3) == 0) ? CSR_DATA_W'($urandom())
                                 : CSR_DATA_W'($urandom_range(0, 823550) - 411775),
                              pick_rate());
         end
         // no idling in the opening phase and in the closing stretch
         if (ph == 0 || ph >= PHASES - 2) begin
            gap_pct   = 0;
            stall_pct = 0;
         end else begin
            gap_pct   = $urandom_range(5, 40);
            stall_pct = $urandom_range(5, 40);
         end
         // hold the result side so the block backs up onto its input
         if (ph == HOLD_PHASE) rsp_hold_cycles = 400;
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            pause_sender();
            roll = $urandom_range(0, 99);
            cmd  = (roll < 5) ? CMD_RESET : CMD_STEP;
            for (int m = 0; m < 3; m++) begin
               if (roll < 20) begin
                  p[m] = longint'($signed(POS_W'($urandom())));
               end else if (roll < 26) begin
                  case ($urandom_range(0, 4))
                     0:       p[m] = POS_HI;
                     1:       p[m] = POS_LO;
                     2:       p[m] = 0;
                     3:       p[m] = -1;
                     default: p[m] = 1;
                  endcase
               end else begin
                  // smooth motion: small random steps around the last angle
                  delta = $urandom_range(0, 1 << $urandom_range(0, 15));
                  p[m]  = $urandom_range(0, 1) ? walk_pos[m] + delta : walk_pos[m] - delta;
                  if (p[m] > POS_HI) p[m] = POS_HI;
                  if (p[m] < POS_LO) p[m] = POS_LO;
               end
               walk_pos[m] = p[m];
            end
            send_item(cmd, p[0], p[1], p[2], 1'b0, no_volts);
         end
      end

      req_ch.valid <= 1'b0;
      wait_drained();
      repeat (30) @(posedge clock);
      if (awaited_drive.size() != 0) begin
         report_mismatch($sformatf("%0d drive results never arrived", awaited_drive.size()));
      end
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
